>>> rtl/decimal_string_to_mbf_float_top_assert.svh
// Assertion macros for the decimal string to MBF float block.
// Used by the bound checker module; needs nothing else.
`ifndef DECIMAL_STRING_TO_MBF_FLOAT_TOP_ASSERT_SVH
`define DECIMAL_STRING_TO_MBF_FLOAT_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DSMBF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dsmbf assertion failed");

// Next-cycle implication, disabled during reset.
`define DSMBF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dsmbf assertion failed");

`endif

>>> rtl/dsmbf_pkg.sv
// Package for the decimal string to MBF float block.
// Status codes, field widths and fixed constants; no dependencies.
`default_nettype none

package dsmbf_pkg;

    localparam int CHAR_W = 8;
    localparam int ACC_W  = 32;
    localparam int EXP_W  = 8;
    localparam int CNT_W  = 6;

    localparam logic [ACC_W-1:0] DIGIT_LIMIT_RESET = 32'd429496729;
    localparam logic [EXP_W-1:0] EXP_BIAS          = 8'h80;
    localparam logic [ACC_W-1:0] MANT_MASK         = 32'h7FFF_FFFF;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_E_LO  = 8'h65;
    localparam logic [CHAR_W-1:0] CH_E_UP  = 8'h45;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SCI  = 2'd1,
        ST_OVF  = 2'd2,
        ST_FRAC = 2'd3
    } t_status;

endpackage

`default_nettype wire

>>> rtl/dsmbf_chan_if.sv
// Valid/ready channel interfaces: character items in, MBF items out.
// Depends on dsmbf_pkg for field widths.
`default_nettype none

interface dsmbf_char_if import dsmbf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              last_char;

    modport source (output valid, output character, output last_char, input ready);
    modport sink   (input valid, input character, input last_char, output ready);
endinterface

interface dsmbf_mbf_if import dsmbf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [EXP_W-1:0] mbf_exponent;
    logic [ACC_W-1:0] packed_mantissa;
    logic [1:0]       status;

    modport source (output valid, output mbf_exponent, output packed_mantissa,
                    output status, input ready);
    modport sink   (input valid, input mbf_exponent, input packed_mantissa,
                    input status, output ready);
endinterface

`default_nettype wire

>>> rtl/decimal_string_to_mbf_float_top.sv
// Decimal string to 40-bit MBF float converter, top level.
// Depends on dsmbf_pkg and the channel interfaces in dsmbf_chan_if.sv.
// Usage:
//   i_char_ch carries one ASCII character per item; last_char marks the end
//   of a string. o_mbf_ch carries one MBF result per string: exponent byte,
//   packed mantissa (sign in bit 31) and status.
//   i_cfg_we / i_cfg_data write the digit limit; write only while idle.
// Timing:
//   One character is accepted per cycle while i_char_ch.ready is high. The
//   string state updates at the accept edge; a final character is captured
//   into a holding register, normalized (leading-one search and shift) from
//   there and moved into the output register once that is free. Throughput
//   is one item per cycle while o_mbf_ch.ready stays high.
// Reset:
//   i_rst_n is synchronous, active low. It clears the string state, the
//   holding and output valid flags and restores the digit limit default.
// Stall:
//   When o_mbf_ch.ready is low the output holds. Characters keep flowing
//   until a second finished string fills the holding register; only then
//   does i_char_ch.ready drop.
`default_nettype none

module decimal_string_to_mbf_float_top import dsmbf_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [ACC_W-1:0] i_cfg_data,
    dsmbf_char_if.sink            i_char_ch,
    dsmbf_mbf_if.source           o_mbf_ch
);

    // string state
    logic [ACC_W-1:0] r_limit;
    logic [ACC_W-1:0] r_acc,   n_acc;
    logic             r_neg,   n_neg;
    logic             r_stop,  n_stop;
    logic             r_point, n_point;
    logic             r_exp,   n_exp;
    logic             r_ovf,   n_ovf;
    logic             r_first;

    // holding register for a finished string
    logic             r_snap_valid;
    logic [ACC_W-1:0] r_snap_acc;
    logic             r_snap_neg;
    logic             r_snap_point;
    logic             r_snap_exp;
    logic             r_snap_ovf;

    // output register
    logic             r_out_valid;
    logic [EXP_W-1:0] r_out_exp;
    logic [ACC_W-1:0] r_out_mant;
    t_status          r_out_status;

    logic             w_accept;
    logic             w_snap_move;
    logic [CHAR_W-1:0] w_ch;
    logic             w_is_digit;
    logic             w_is_sign;
    logic             w_proceed;
    logic [ACC_W+3:0] w_prod;
    logic             w_ovf_hit;

    logic [CNT_W-1:0] w_bits;
    logic [CNT_W-1:0] w_shamt;
    logic [ACC_W-1:0] w_norm;
    t_status          w_status;
    logic [EXP_W-1:0] w_exp;
    logic [ACC_W-1:0] w_mant;

    assign w_snap_move     = r_snap_valid && (!r_out_valid || o_mbf_ch.ready);
    assign i_char_ch.ready = !r_snap_valid || w_snap_move;
    assign w_accept        = i_char_ch.valid && i_char_ch.ready;

    assign w_ch       = i_char_ch.character;
    assign w_is_digit = (w_ch >= CH_ZERO) && (w_ch <= CH_NINE);
    assign w_is_sign  = r_first && ((w_ch == CH_MINUS) || (w_ch == CH_PLUS));
    assign w_proceed  = !w_is_sign && !r_stop && !r_ovf;
    // acc * 10 + digit as two shifted adds
    assign w_prod     = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                      + {{(ACC_W){1'b0}}, w_ch[3:0]};
    assign w_ovf_hit  = (r_acc >= r_limit) || (w_prod[ACC_W+3:ACC_W] != 4'd0);

    always_comb begin
        n_acc   = r_acc;
        n_neg   = r_neg;
        n_stop  = r_stop;
        n_point = r_point;
        n_exp   = r_exp || (w_ch == CH_E_LO) || (w_ch == CH_E_UP);
        n_ovf   = r_ovf;
        if (w_is_sign) begin
            n_neg = (w_ch == CH_MINUS);
        end else if (w_proceed) begin
            if (w_is_digit) begin
                if (w_ovf_hit) begin
                    n_ovf = 1'b1;
                end else begin
                    n_acc = w_prod[ACC_W-1:0];
                end
            end else begin
                n_stop = 1'b1;
                if (w_ch == CH_POINT) begin
                    n_point = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= DIGIT_LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_stop  <= 1'b0;
            r_point <= 1'b0;
            r_exp   <= 1'b0;
            r_ovf   <= 1'b0;
            r_first <= 1'b1;
        end else if (w_accept) begin
            if (i_char_ch.last_char) begin
                r_acc   <= '0;
                r_neg   <= 1'b0;
                r_stop  <= 1'b0;
                r_point <= 1'b0;
                r_exp   <= 1'b0;
                r_ovf   <= 1'b0;
                r_first <= 1'b1;
            end else begin
                r_acc   <= n_acc;
                r_neg   <= n_neg;
                r_stop  <= n_stop;
                r_point <= n_point;
                r_exp   <= n_exp;
                r_ovf   <= n_ovf;
                r_first <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (w_accept && i_char_ch.last_char) begin
            r_snap_valid <= 1'b1;
        end else if (w_snap_move) begin
            r_snap_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_char_ch.last_char) begin
            r_snap_acc   <= n_acc;
            r_snap_neg   <= n_neg;
            r_snap_point <= n_point;
            r_snap_exp   <= n_exp;
            r_snap_ovf   <= n_ovf;
        end
    end

    // significant bit count: position of leading one plus one
    always_comb begin
        w_bits = '0;
        for (int i = 0; i < ACC_W; i++) begin
            if (r_snap_acc[i]) begin
                w_bits = CNT_W'(i + 1);
            end
        end
    end

    assign w_shamt = CNT_W'(ACC_W) - w_bits;
    assign w_norm  = r_snap_acc << w_shamt[CNT_W-2:0];

    always_comb begin
        w_status = ST_OK;
        w_exp    = '0;
        w_mant   = '0;
        if (r_snap_exp) begin
            w_status = ST_SCI;
        end else if (r_snap_ovf) begin
            w_status = ST_OVF;
        end else if (r_snap_point && (r_snap_acc == '0)) begin
            w_status = ST_FRAC;
        end else if (r_snap_acc != '0) begin
            w_exp  = EXP_BIAS + {{(EXP_W-CNT_W){1'b0}}, w_bits};
            w_mant = (w_norm & MANT_MASK) | {r_snap_neg, {(ACC_W-1){1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_snap_move) begin
            r_out_valid <= 1'b1;
        end else if (o_mbf_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_snap_move) begin
            r_out_exp    <= w_exp;
            r_out_mant   <= w_mant;
            r_out_status <= w_status;
        end
    end

    assign o_mbf_ch.valid           = r_out_valid;
    assign o_mbf_ch.mbf_exponent    = r_out_exp;
    assign o_mbf_ch.packed_mantissa = r_out_mant;
    assign o_mbf_ch.status          = r_out_status;

endmodule

`default_nettype wire

>>> rtl/dsmbf_checker.sv
// Port-level checker for the MBF output channel, bound to the top level.
// Depends on dsmbf_pkg and decimal_string_to_mbf_float_top_assert.svh.
`default_nettype none

`include "decimal_string_to_mbf_float_top_assert.svh"

module dsmbf_checker import dsmbf_pkg::*; (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_valid,
    input wire logic             i_ready,
    input wire logic [EXP_W-1:0] i_exp,
    input wire logic [ACC_W-1:0] i_mant,
    input wire logic [1:0]       i_status
);

    `DSMBF_ASSERT_NEXT(a_valid_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid)

    `DSMBF_ASSERT_NEXT(a_item_hold, i_clk, i_rst_n, i_valid && !i_ready, $stable(i_exp) && $stable(i_mant) && $stable(i_status))

    // error items carry no number
    `DSMBF_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, i_valid && (i_status != ST_OK), (i_exp == '0) && (i_mant == '0))

    // zero has no sign and no mantissa
    `DSMBF_ASSERT_NOW(a_zero_clean, i_clk, i_rst_n, i_valid && (i_exp == '0), i_mant == '0)

    // a 32-bit integer has 1 to 32 significant bits
    `DSMBF_ASSERT_NOW(a_exp_range, i_clk, i_rst_n, i_valid && (i_exp != '0), (i_exp > EXP_BIAS) && (i_exp <= EXP_BIAS + 8'd32))

endmodule

bind decimal_string_to_mbf_float_top dsmbf_checker u_dsmbf_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_mbf_ch.valid),
    .i_ready  (o_mbf_ch.ready),
    .i_exp    (o_mbf_ch.mbf_exponent),
    .i_mant   (o_mbf_ch.packed_mantissa),
    .i_status (o_mbf_ch.status)
);

`default_nettype wire

>>> test/tb_top.sv
// Testbench for decimal_string_to_mbf_float_top: streams decimal strings one
// character per item and checks every MBF result against an in-bench model.
// Depends on dsmbf_pkg, dsmbf_chan_if.sv and the top-level RTL.
`timescale 1ns / 1ps

module tb_top import dsmbf_pkg::*; ();

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_char_item;

    typedef struct packed {
        logic [EXP_W-1:0] exponent;
        logic [ACC_W-1:0] mantissa;
        t_status          status;
    } t_mbf_word;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [ACC_W-1:0] i_cfg_data;

    dsmbf_char_if chr_if();
    dsmbf_mbf_if  mbf_if();

    decimal_string_to_mbf_float_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_char_ch  (chr_if),
        .o_mbf_ch   (mbf_if)
    );

    // converter state mirror
    logic [ACC_W-1:0] limit_q;
    logic [ACC_W-1:0] acc_q;
    bit               neg_q, stopped_q, point_q, emark_q, ovf_q, first_q;

    t_char_item  char_queue[$];
    t_mbf_word   mbf_expected[$];
    logic [7:0]  str_buf[$];

    int  chars_queued;
    int  chars_taken;
    int  mismatches;
    int  idle_cycles;
    int  src_idle_pct;
    int  snk_stall_pct;
    int  holdoff_asks;
    int  holdoff_served;
    int  hold_left;
    bit  took_in;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic bit chance(int pct);
        return $urandom_range(99, 0) < pct;
    endfunction

    function automatic void clear_string();
        acc_q     = '0;
        neg_q     = 1'b0;
        stopped_q = 1'b0;
        point_q   = 1'b0;
        emark_q   = 1'b0;
        ovf_q     = 1'b0;
        first_q   = 1'b1;
    endfunction

    function automatic bit convert_char(input logic [CHAR_W-1:0] ch, input logic last,
                                        output t_mbf_word r);
        bit          first;
        logic [63:0] wide;
        int          nbits;
        first   = first_q;
        first_q = 1'b0;
        if (ch == CH_E_LO || ch == CH_E_UP)
            emark_q = 1'b1;
        if (first && (ch == CH_MINUS || ch == CH_PLUS)) begin
            neg_q = (ch == CH_MINUS);
        end else if (!stopped_q && !ovf_q) begin
            if (ch >= CH_ZERO && ch <= CH_NINE) begin
                wide = {32'd0, acc_q} * 64'd10 + {56'd0, ch - CH_ZERO};
                if (acc_q >= limit_q || wide[63:32] != 0)
                    ovf_q = 1'b1;
                else
                    acc_q = wide[31:0];
            end else begin
                stopped_q = 1'b1;
                if (ch == CH_POINT)
                    point_q = 1'b1;
            end
        end
        r = '{exponent: '0, mantissa: '0, status: ST_OK};
        if (!last)
            return 1'b0;
        if (emark_q) begin
            r.status = ST_SCI;
        end else if (ovf_q) begin
            r.status = ST_OVF;
        end else if (point_q && acc_q == 0) begin
            r.status = ST_FRAC;
        end else if (acc_q != 0) begin
            nbits = 0;
            for (int i = 0; i < ACC_W; i++)
                if (acc_q[i])
                    nbits = i + 1;
            r.exponent = EXP_BIAS + EXP_W'(nbits);
            r.mantissa = (acc_q << (ACC_W - nbits)) & MANT_MASK;
            r.mantissa[ACC_W-1] = neg_q;
        end
        clear_string();
        return 1'b1;
    endfunction

    // string building
    task automatic put(input logic [7:0] ch);
        str_buf.push_back(ch);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put(s[i]);
    endtask

    task automatic put_digits(input int n);
        repeat (n) put(CH_ZERO + 8'($urandom_range(9, 0)));
    endtask

    task automatic flush_string();
        foreach (str_buf[i]) begin
            char_queue.push_back('{ch: str_buf[i], last: (i == str_buf.size() - 1)});
            chars_queued++;
        end
        str_buf.delete();
    endtask

    task automatic add_text(input string s);
        put_text(s);
        flush_string();
    endtask

    task automatic add_random_number();
        int kind;
        int sel;
        kind = $urandom_range(99, 0);
        if (kind < 8) begin
            repeat ($urandom_range(4, 1)) put(8'($urandom_range(255, 0)));
        end else if (kind < 14) begin
            // right at the 32-bit and default-limit boundary
            if (chance(50))
                put(CH_MINUS);
            put_text("429496729");
            if (chance(70))
                put_digits(1);
            if (chance(30))
                put_digits(1);
        end else begin
            sel = $urandom_range(2, 0);
            if (sel == 1)
                put(CH_MINUS);
            else if (sel == 2)
                put(CH_PLUS);
            put_digits(chance(20) ? $urandom_range(12, 9) : $urandom_range(5, 0));
            if (chance(40)) begin
                put(CH_POINT);
                put_digits($urandom_range(4, 0));
            end
            if (chance(12)) begin
                put(chance(50) ? CH_E_LO : CH_E_UP);
                if (chance(40))
                    put(CH_MINUS);
                put_digits($urandom_range(2, 1));
            end
            if (chance(6))
                str_buf.insert($urandom_range(str_buf.size(), 0), 8'($urandom_range(255, 0)));
        end
        if (str_buf.size() == 0)
            put_digits(1);
        flush_string();
    endtask

    task automatic add_random(input int n);
        int start;
        start = chars_queued;
        while (chars_queued - start < n)
            add_random_number();
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (chars_taken != chars_queued || mbf_expected.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic start_phase(input logic [ACC_W-1:0] lim, input int src, input int snk);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= lim;
        @(negedge i_clk);
        i_cfg_we      <= 1'b0;
        src_idle_pct  = src;
        snk_stall_pct = snk;
    endtask

    // main sequence
    initial begin
        logic [ACC_W-1:0] rnd_lim;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_data       = '0;
        src_idle_pct     = 0;
        snk_stall_pct    = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        start_phase(DIGIT_LIMIT_RESET, 0, 0);
        add_text("7");
        add_text("-0");
        add_text("+5");
        add_text(".5");
        add_text("3e");
        put(8'hFF);
        flush_string();
        put(8'h00);
        flush_string();
        add_text("-12.9");
        add_text("E");
        add_text("-");
        add_text("0.25");
        add_random(230);

        start_phase(32'hFFFF_FFFF, 63, 0);
        add_random(260);

        start_phase(32'd1, 0, 63);
        add_random(250);

        rnd_lim = $urandom() >> $urandom_range(28, 4);
        if (rnd_lim == 0)
            rnd_lim = 32'd1;
        start_phase(rnd_lim, 29, 29);
        add_random(250);

        // long output stall with the sender still pushing
        start_phase(DIGIT_LIMIT_RESET, 0, 0);
        add_random(250);
        holdoff_asks++;

        start_phase(32'd1000, 0, 0);
        add_random(250);

        wait_drained();
        repeat (8) @(negedge i_clk);
        if (mismatches == 0 && mbf_expected.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // character driver
    always @(negedge i_clk) begin
        t_char_item nx;
        if (!i_rst_n) begin
            chr_if.valid <= 1'b0;
        end else if (!chr_if.valid || took_in) begin
            if (char_queue.size() > 0 && !chance(src_idle_pct)) begin
                nx = char_queue.pop_front();
                chr_if.character <= nx.ch;
                chr_if.last_char <= nx.last;
                chr_if.valid     <= 1'b1;
            end else begin
                chr_if.valid <= 1'b0;
            end
        end
    end

    // result sink
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            mbf_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            mbf_if.ready <= 1'b0;
        end else if (holdoff_served != holdoff_asks) begin
            holdoff_served++;
            hold_left = HOLD_CYCLES - 1;
            mbf_if.ready <= 1'b0;
        end else begin
            mbf_if.ready <= !chance(snk_stall_pct);
        end
    end

    // prediction, checking and watchdog
    always @(posedge i_clk) begin
        t_mbf_word r;
        t_mbf_word e;
        bit        took_out;
        took_out = 1'b0;
        if (!i_rst_n) begin
            limit_q = DIGIT_LIMIT_RESET;
            clear_string();
            took_in = 1'b0;
        end else begin
            if (i_cfg_we)
                limit_q = i_cfg_data;
            took_in = chr_if.valid && chr_if.ready;
            if (took_in) begin
                chars_taken++;
                if (convert_char(chr_if.character, chr_if.last_char, r))
                    mbf_expected.push_back(r);
            end
            took_out = mbf_if.valid && mbf_if.ready;
            if (took_out) begin
                if (mbf_expected.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result: exp=%h mant=%h st=%0d",
                                 mbf_if.mbf_exponent, mbf_if.packed_mantissa,
                                 mbf_if.status);
                end else begin
                    e = mbf_expected.pop_front();
                    if (mbf_if.mbf_exponent !== e.exponent ||
                        mbf_if.packed_mantissa !== e.mantissa ||
                        mbf_if.status !== e.status) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("mismatch: expected exp=%h mant=%h st=%0d, got exp=%h mant=%h st=%0d",
                                     e.exponent, e.mantissa, e.status, mbf_if.mbf_exponent,
                                     mbf_if.packed_mantissa, mbf_if.status);
                    end
                end
            end
        end
        if (!i_rst_n || took_in || took_out || i_cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d cycles without progress", idle_cycles);
            $display("FAIL");
            $finish;
        end
    end

endmodule
